### hw/rtl/gau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gau_pkg
// Types and constants shared by the group aggregate unit.
// ----------------------------------------------------------------------------
package gau_pkg;

  localparam logic [3:0] MODE_FIRST   = 4'd0;
  localparam logic [3:0] MODE_LAST    = 4'd1;
  localparam logic [3:0] MODE_SUM     = 4'd2;
  localparam logic [3:0] MODE_AVERAGE = 4'd3;
  localparam logic [3:0] MODE_MINIMUM = 4'd4;
  localparam logic [3:0] MODE_MAXIMUM = 4'd5;
  localparam logic [3:0] MODE_COUNT   = 4'd6;
  localparam logic [3:0] MODE_FIELD   = 4'd7;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [3:0] {
    OP_FIRST,
    OP_LAST,
    OP_SUM,
    OP_AVG,
    OP_MIN,
    OP_MAX,
    OP_COUNT,
    OP_NONE,
    OP_CLOSE_VALUE,
    OP_CLOSE_AVG,
    OP_CLOSE_COUNT,
    OP_CLOSE_BAD
  } op_t;

  typedef struct packed {
    logic        mode;
    logic [63:0] sample_value;
  } in_t;

  typedef struct packed {
    logic        changed;
    logic [63:0] group_value;
    logic [31:0] group_count;
    logic        bad_mode;
  } out_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] sample;
  } cmd_t;

endpackage
`default_nettype wire

### hw/rtl/gau_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gau_front
// Holds the aggregate mode and turns each input transaction into a command.
// ----------------------------------------------------------------------------
module gau_front import gau_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_t        in_data,
  output logic            q_push,
  output cmd_t            q_data,
  input  wire logic       q_full
);

  logic [3:0] mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FIRST;
    end else if (cfg_we) begin
      mode_r <= cfg_data;
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.sample = in_data.sample_value;
    if (!in_data.mode) begin
      case (mode_r)
        MODE_FIRST:   q_data.op = OP_FIRST;
        MODE_LAST:    q_data.op = OP_LAST;
        MODE_FIELD:   q_data.op = OP_LAST;
        MODE_SUM:     q_data.op = OP_SUM;
        MODE_AVERAGE: q_data.op = OP_AVG;
        MODE_MINIMUM: q_data.op = OP_MIN;
        MODE_MAXIMUM: q_data.op = OP_MAX;
        MODE_COUNT:   q_data.op = OP_COUNT;
        default:      q_data.op = OP_NONE;
      endcase
    end else begin
      case (mode_r)
        MODE_FIRST, MODE_LAST, MODE_SUM, MODE_MINIMUM, MODE_MAXIMUM, MODE_FIELD:
          q_data.op = OP_CLOSE_VALUE;
        MODE_AVERAGE: q_data.op = OP_CLOSE_AVG;
        MODE_COUNT:   q_data.op = OP_CLOSE_COUNT;
        default:      q_data.op = OP_CLOSE_BAD;
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/gau_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gau_queue
// Small command queue between the front and the back.
// ----------------------------------------------------------------------------
module gau_queue import gau_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_data,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_data,
  output logic      valid
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  cmd_t                mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r;
  logic [PTR_BITS-1:0] rd_ptr_r;
  logic [CNT_BITS-1:0] cnt_r;

  assign full     = (cnt_r == CNT_BITS'(QUEUE_DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/gau_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gau_divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gau_divider #(
  parameter int COUNT_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [63:0]           dividend,
  input  wire logic [COUNT_BITS-1:0] divisor,
  output logic                       done,
  output logic [63:0]                quotient
);

  logic [COUNT_BITS:0]   rem_r;
  logic [63:0]           quo_r;
  logic [COUNT_BITS-1:0] div_r;
  logic [5:0]            cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [COUNT_BITS:0]   shifted;
  logic                  take;

  assign shifted  = {rem_r[COUNT_BITS-1:0], quo_r[63]};
  assign take     = (shifted >= {1'b0, div_r});
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? shifted - {1'b0, div_r} : shifted;
      quo_r <= {quo_r[62:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= '0;
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == 6'd63) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/gau_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gau_back
// Executes queued commands against the running state and drives results.
// ----------------------------------------------------------------------------
module gau_back import gau_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  input  wire cmd_t                  q_data,
  output logic                       q_pop,
  output logic                       div_start,
  output logic [63:0]                div_dividend,
  output logic [COUNT_BITS-1:0]      div_divisor,
  input  wire logic                  div_done,
  input  wire logic [63:0]           div_quotient,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_t                       out_data
);

  typedef enum logic {
    S_EXEC,
    S_DIV
  } state_t;

  state_t                state_r, state_nxt;
  logic [63:0]           rv_r, rv_nxt;
  logic [COUNT_BITS-1:0] rc_r, rc_nxt;
  logic                  have_r, have_nxt;
  logic [63:0]           sv_r, sv_nxt;
  logic [COUNT_BITS-1:0] sc_r, sc_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_data_r, out_data_nxt;
  logic                  out_free;
  logic [COUNT_BITS-1:0] rc_inc;
  logic                  changed;
  logic                  bad;
  logic                  emit;
  logic [63:0]           sc_ext;

  assign out_free     = !out_valid_r || out_ready;
  assign q_pop        = q_valid && (state_r == S_EXEC) && out_free;
  assign rc_inc       = (rc_r == '1) ? rc_r : rc_r + 1'b1;
  assign div_dividend = rv_r;
  assign div_divisor  = rc_r;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign sc_ext       = 64'(sc_nxt);

  always_comb begin
    state_nxt = state_r;
    rv_nxt    = rv_r;
    rc_nxt    = rc_r;
    have_nxt  = have_r;
    sv_nxt    = sv_r;
    sc_nxt    = sc_r;
    changed   = 1'b0;
    bad       = 1'b0;
    emit      = 1'b0;
    div_start = 1'b0;
    if (q_pop) begin
      emit = 1'b1;
      case (q_data.op)
        OP_FIRST: begin
          if (!have_r) begin
            rv_nxt   = q_data.sample;
            have_nxt = 1'b1;
            changed  = 1'b1;
          end
        end
        OP_LAST: begin
          rv_nxt  = q_data.sample;
          changed = 1'b1;
        end
        OP_SUM: begin
          rv_nxt  = rv_r + q_data.sample;
          changed = 1'b1;
        end
        OP_AVG: begin
          rv_nxt  = rv_r + q_data.sample;
          rc_nxt  = rc_inc;
          changed = 1'b1;
        end
        OP_MIN: begin
          if (!have_r || (q_data.sample < rv_r)) begin
            rv_nxt   = q_data.sample;
            have_nxt = 1'b1;
            changed  = 1'b1;
          end
        end
        OP_MAX: begin
          if (!have_r || (q_data.sample > rv_r)) begin
            rv_nxt   = q_data.sample;
            have_nxt = 1'b1;
            changed  = 1'b1;
          end
        end
        OP_COUNT: begin
          rc_nxt  = rc_inc;
          changed = 1'b1;
        end
        OP_NONE: begin
          changed = 1'b1;
        end
        OP_CLOSE_VALUE: begin
          sv_nxt   = rv_r;
          rv_nxt   = '0;
          rc_nxt   = '0;
          have_nxt = 1'b0;
        end
        OP_CLOSE_COUNT: begin
          sc_nxt   = rc_r;
          rv_nxt   = '0;
          rc_nxt   = '0;
          have_nxt = 1'b0;
        end
        OP_CLOSE_AVG: begin
          rv_nxt   = '0;
          rc_nxt   = '0;
          have_nxt = 1'b0;
          if (rc_r == '0) begin
            sv_nxt = '0;
          end else begin
            div_start = 1'b1;
            emit      = 1'b0;
            state_nxt = S_DIV;
          end
        end
        default: begin
          bad = 1'b1;
        end
      endcase
    end else if ((state_r == S_DIV) && div_done && out_free) begin
      sv_nxt    = div_quotient;
      emit      = 1'b1;
      state_nxt = S_EXEC;
    end

    out_data_nxt             = out_data_r;
    out_data_nxt.changed     = changed;
    out_data_nxt.group_value = sv_nxt;
    out_data_nxt.group_count = sc_ext[31:0];
    out_data_nxt.bad_mode    = bad;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
      out_data_nxt  = out_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_EXEC;
      rv_r        <= '0;
      rc_r        <= '0;
      have_r      <= 1'b0;
      sv_r        <= '0;
      sc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rv_r        <= rv_nxt;
      rc_r        <= rc_nxt;
      have_r      <= have_nxt;
      sv_r        <= sv_nxt;
      sc_r        <= sc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

### hw/rtl/group_aggregate_u64_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// group_aggregate_u64_unit
// Running first/last/sum/average/min/max/count aggregate of one group.
// ----------------------------------------------------------------------------
// Results are registered in the queue and the output register; an average
// close with a nonzero count also waits on the 64-step serial divider.
// Throughput: one transaction per cycle unless out_ready or a full queue stalls
// it; an average close holds the back end during the divide as the queue fills.
// Reset: synchronous active-low rst_n clears the mode and all running and
// saved state at once; there is no clearing pass.
module group_aggregate_u64_unit import gau_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_t        in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_t            out_data
);

  logic                  q_push;
  cmd_t                  q_wdata;
  logic                  q_full;
  logic                  q_pop;
  cmd_t                  q_rdata;
  logic                  q_valid;
  logic                  div_start;
  logic [63:0]           div_dividend;
  logic [COUNT_BITS-1:0] div_divisor;
  logic                  div_done;
  logic [63:0]           div_quotient;

  gau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full)
  );

  gau_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .valid     (q_valid)
  );

  gau_divider #(.COUNT_BITS(COUNT_BITS)) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  gau_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quotient (div_quotient),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule
`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for group_aggregate_u64_unit. A directed run walks the
// first/min/max/average/count/sum modes and two unused codes, with extreme
// samples and an empty group; random phases of grouped updates and repeated
// closes under random stalls on both sides are checked by a bit-accurate model.
// ----------------------------------------------------------------------------
module tb;
  import gau_pkg::*;

  localparam logic [3:0] MODE_NONE   = 4'd8;
  localparam logic [3:0] MODE_UNUSED = 4'd15;
  localparam logic       ITEM_UPDATE = 1'b0;
  localparam logic       ITEM_CLOSE  = 1'b1;
  localparam int         CYCLE_LIMIT = 2000000;
  localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

  class group_aggregate_tracker;
    logic [3:0]  agg_mode;
    logic [63:0] run_value;
    logic [31:0] run_count;
    logic        have_value;
    logic [63:0] saved_value;
    logic [31:0] saved_count;
    out_t        pending_results[$];
    int          errors;

    function new();
      agg_mode    = MODE_FIRST;
      run_value   = '0;
      run_count   = '0;
      have_value  = 1'b0;
      saved_value = '0;
      saved_count = '0;
      errors      = 0;
    endfunction

    function void set_mode(logic [3:0] m);
      agg_mode = m;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void bump_count();
      if (run_count != '1) run_count = run_count + 1'b1;
    endfunction

    function out_t fold_item(in_t item);
      out_t        res;
      logic        changed;
      logic        bad;
      logic [63:0] v;
      changed = 1'b0;
      bad     = 1'b0;
      v       = item.sample_value;
      if (item.mode == ITEM_UPDATE) begin
        changed = 1'b1;
        case (agg_mode)
          MODE_FIRST: begin
            if (!have_value) begin
              run_value  = v;
              have_value = 1'b1;
            end else begin
              changed = 1'b0;
            end
          end
          MODE_LAST, MODE_FIELD: run_value = v;
          MODE_SUM: run_value = run_value + v;
          MODE_AVERAGE: begin
            run_value = run_value + v;
            bump_count();
          end
          MODE_MINIMUM, MODE_MAXIMUM: begin
            if (!have_value) begin
              run_value  = v;
              have_value = 1'b1;
            end else if ((agg_mode == MODE_MINIMUM && v < run_value) ||
                         (agg_mode == MODE_MAXIMUM && v > run_value)) begin
              run_value = v;
            end else begin
              changed = 1'b0;
            end
          end
          MODE_COUNT: bump_count();
          default: ;
        endcase
      end else begin
        case (agg_mode)
          MODE_FIRST, MODE_LAST, MODE_SUM, MODE_MINIMUM, MODE_MAXIMUM, MODE_FIELD:
            saved_value = run_value;
          MODE_AVERAGE:
            saved_value = (run_count == '0) ? 64'd0 : run_value / {32'd0, run_count};
          MODE_COUNT: saved_count = run_count;
          default: bad = 1'b1;
        endcase
        if (!bad) begin
          run_value  = '0;
          run_count  = '0;
          have_value = 1'b0;
        end
      end
      res.changed     = changed;
      res.group_value = saved_value;
      res.group_count = saved_count;
      res.bad_mode    = bad;
      return res;
    endfunction

    function void note_sample(in_t item);
      pending_results.push_back(fold_item(item));
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with no transaction pending, expected none actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("changed", 64'(want.changed), 64'(got.changed));
      compare_field("group_value", want.group_value, got.group_value);
      compare_field("group_count", 64'(want.group_count), 64'(got.group_count));
      compare_field("bad_mode", 64'(want.bad_mode), 64'(got.bad_mode));
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [3:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  in_t        in_data;
  logic       out_valid;
  logic       out_ready;
  out_t       out_data;
  bit         no_gaps;
  int         cycle_count = 0;

  group_aggregate_tracker sb = new();

  group_aggregate_u64_unit #(.COUNT_BITS(32)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("group_aggregate_u64_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_mode(cfg_data);
      if (in_valid && in_ready) sb.note_sample(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 64'd0;
    if (r < 24) return ALL_ONES;
    if (r < 50) return 64'($urandom_range(0, 20));
    if (r < 65) return {32'hFFFF_FFFF, 32'($urandom)};
    return {32'($urandom), 32'($urandom)};
  endfunction

  function automatic int pick_group_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 8);
    if (r < 95) return $urandom_range(9, 30);
    return $urandom_range(31, 80);
  endfunction

  initial begin
    int stall;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        stall = pick_gap();
        out_ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  task automatic send_item(input in_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_update(input logic [63:0] v);
    in_t item;
    item.mode         = ITEM_UPDATE;
    item.sample_value = v;
    send_item(item);
  endtask

  task automatic send_close();
    in_t item;
    item.mode         = ITEM_CLOSE;
    item.sample_value = {32'($urandom), 32'($urandom)};
    send_item(item);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic apply_mode(input logic [3:0] m);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic run_phase(input logic [3:0] m, input int target);
    int  sent;
    int  len;
    int  r;
    bit  paused;
    sent   = 0;
    paused = 1'b0;
    apply_mode(m);
    while (sent < target) begin
      len = pick_group_len();
      for (int k = 0; k < len && sent < target; k++) begin
        send_update(pick_value());
        sent++;
      end
      r = $urandom_range(0, 99);
      if (r < 85) begin
        send_close();
        sent++;
      end else if (r < 93) begin
        send_close();
        send_close();
        sent += 2;
      end
      if (!paused && sent >= target / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    no_gaps     = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    apply_mode(MODE_FIRST);
    send_update(64'd5);
    send_update(64'd0);
    send_close();

    apply_mode(MODE_MINIMUM);
    send_update(ALL_ONES);
    send_update(ALL_ONES);
    send_update(64'd0);
    send_close();

    apply_mode(MODE_MAXIMUM);
    send_update(64'd0);
    send_update(64'd0);
    send_update(ALL_ONES);
    send_close();

    apply_mode(MODE_AVERAGE);
    send_close();
    send_update(ALL_ONES);
    send_update(ALL_ONES);
    send_update(64'd1);
    send_close();

    apply_mode(MODE_COUNT);
    send_update(ALL_ONES);
    send_update(64'd0);
    send_close();

    apply_mode(MODE_SUM);
    send_update(ALL_ONES);
    send_update(64'd2);
    send_close();

    apply_mode(MODE_NONE);
    send_update(ALL_ONES);
    send_close();

    apply_mode(MODE_UNUSED);
    send_update(64'd7);
    send_close();

    for (int p = 0; p < 24; p++) begin
      no_gaps = (p % 6 == 3);
      if (p < 16)
        run_phase(4'(p), (p >= 8) ? 30 : 85);
      else
        run_phase(4'($urandom_range(0, 7)), 85);
    end
    no_gaps = 1'b0;

    wait_drained();
    repeat (70) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("group_aggregate_u64_unit verification clean");
    end else begin
      $display("group_aggregate_u64_unit verification failed");
    end
    $finish;
  end

endmodule
